@@ sv/bitsort8_pkg.sv @@
package bitsort8_pkg;

    localparam int WORD_WIDTH = 64;
    localparam int NUM_ELEMS = 8;
    localparam int NUM_STAGES = 6;
    localparam int PAIRS_PER_STAGE = 4;

    // Comparator positions for each layer of the network: the lower index
    // receives the smaller word.
    localparam logic [2:0] PAIR_LO [NUM_STAGES][PAIRS_PER_STAGE] = '{
        '{3'd0, 3'd2, 3'd4, 3'd6},
        '{3'd0, 3'd1, 3'd4, 3'd5},
        '{3'd0, 3'd2, 3'd4, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd0, 3'd1, 3'd4, 3'd5},
        '{3'd0, 3'd2, 3'd4, 3'd6}
    };

    localparam logic [2:0] PAIR_HI [NUM_STAGES][PAIRS_PER_STAGE] = '{
        '{3'd1, 3'd3, 3'd5, 3'd7},
        '{3'd3, 3'd2, 3'd7, 3'd6},
        '{3'd1, 3'd3, 3'd5, 3'd7},
        '{3'd7, 3'd6, 3'd5, 3'd4},
        '{3'd2, 3'd3, 3'd6, 3'd7},
        '{3'd1, 3'd3, 3'd5, 3'd7}
    };

endpackage

@@ sv/bitsort8_stage.sv @@
module bitsort8_stage #(
    parameter int WORD_WIDTH = bitsort8_pkg::WORD_WIDTH,
    parameter int STAGE = 0
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  logic                                               in_valid,
    output logic                                               in_ready,
    input  logic [bitsort8_pkg::NUM_ELEMS-1:0][WORD_WIDTH-1:0] in_data,
    output logic                                               out_valid,
    input  logic                                               out_ready,
    output logic [bitsort8_pkg::NUM_ELEMS-1:0][WORD_WIDTH-1:0] out_data
);

    logic                                               valid_reg;
    logic [bitsort8_pkg::NUM_ELEMS-1:0][WORD_WIDTH-1:0] data_reg;
    logic [bitsort8_pkg::NUM_ELEMS-1:0][WORD_WIDTH-1:0] data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        logic [WORD_WIDTH-1:0] a;
        logic [WORD_WIDTH-1:0] b;
        data_next = in_data;
        for (int p = 0; p < bitsort8_pkg::PAIRS_PER_STAGE; p++) begin
            a = in_data[bitsort8_pkg::PAIR_LO[STAGE][p]];
            b = in_data[bitsort8_pkg::PAIR_HI[STAGE][p]];
            if (b < a) begin
                data_next[bitsort8_pkg::PAIR_LO[STAGE][p]] = b;
                data_next[bitsort8_pkg::PAIR_HI[STAGE][p]] = a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/bitonic_sort_eight_words64.sv @@
// Channel   Direction  Handshake            Payload
// s_        input      s_valid / s_ready    s_elem_0 .. s_elem_7, WORD_WIDTH bits each
// m_        output     m_valid / m_ready    m_sorted_0 .. m_sorted_7, ascending
//
// Each transaction passes through six registered compare-exchange layers, and
// one transaction can be accepted every cycle while s_ready is high. Reset
// clears only the stage valid bits. A stall on the output holds a full stage
// in place only when every later stage is full as well; empty stages keep
// filling, and s_ready drops only when all six stages hold data.
module bitonic_sort_eight_words64 #(
    parameter int WORD_WIDTH = bitsort8_pkg::WORD_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [WORD_WIDTH-1:0] s_elem_0,
    input  logic [WORD_WIDTH-1:0] s_elem_1,
    input  logic [WORD_WIDTH-1:0] s_elem_2,
    input  logic [WORD_WIDTH-1:0] s_elem_3,
    input  logic [WORD_WIDTH-1:0] s_elem_4,
    input  logic [WORD_WIDTH-1:0] s_elem_5,
    input  logic [WORD_WIDTH-1:0] s_elem_6,
    input  logic [WORD_WIDTH-1:0] s_elem_7,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORD_WIDTH-1:0] m_sorted_0,
    output logic [WORD_WIDTH-1:0] m_sorted_1,
    output logic [WORD_WIDTH-1:0] m_sorted_2,
    output logic [WORD_WIDTH-1:0] m_sorted_3,
    output logic [WORD_WIDTH-1:0] m_sorted_4,
    output logic [WORD_WIDTH-1:0] m_sorted_5,
    output logic [WORD_WIDTH-1:0] m_sorted_6,
    output logic [WORD_WIDTH-1:0] m_sorted_7
);

    localparam int NUM_STAGES = bitsort8_pkg::NUM_STAGES;

    logic [NUM_STAGES:0]                                  valid_chain;
    logic [NUM_STAGES:0]                                  ready_chain;
    logic [bitsort8_pkg::NUM_ELEMS-1:0][WORD_WIDTH-1:0]   data_chain [NUM_STAGES+1];

    assign valid_chain[0] = s_valid;
    assign s_ready        = ready_chain[0];
    assign data_chain[0]  = {s_elem_7, s_elem_6, s_elem_5, s_elem_4,
                             s_elem_3, s_elem_2, s_elem_1, s_elem_0};

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        bitsort8_stage #(
            .WORD_WIDTH(WORD_WIDTH),
            .STAGE     (k)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (valid_chain[k]),
            .in_ready (ready_chain[k]),
            .in_data  (data_chain[k]),
            .out_valid(valid_chain[k+1]),
            .out_ready(ready_chain[k+1]),
            .out_data (data_chain[k+1])
        );
    end

    assign ready_chain[NUM_STAGES] = m_ready;
    assign m_valid    = valid_chain[NUM_STAGES];
    assign m_sorted_0 = data_chain[NUM_STAGES][0];
    assign m_sorted_1 = data_chain[NUM_STAGES][1];
    assign m_sorted_2 = data_chain[NUM_STAGES][2];
    assign m_sorted_3 = data_chain[NUM_STAGES][3];
    assign m_sorted_4 = data_chain[NUM_STAGES][4];
    assign m_sorted_5 = data_chain[NUM_STAGES][5];
    assign m_sorted_6 = data_chain[NUM_STAGES][6];
    assign m_sorted_7 = data_chain[NUM_STAGES][7];

    // Every delivered result is in ascending order.
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sorted_0 <= m_sorted_1) && (m_sorted_1 <= m_sorted_2) &&
                    (m_sorted_2 <= m_sorted_3) && (m_sorted_3 <= m_sorted_4) &&
                    (m_sorted_4 <= m_sorted_5) && (m_sorted_5 <= m_sorted_6) &&
                    (m_sorted_6 <= m_sorted_7))
        else $error("result not in ascending order");

    // The input stalls only when the whole pipeline is full and the output is held.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_chain[NUM_STAGES:1]) && !m_ready)
        else $error("input stalled while a stage was free");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

@@ verif/tb_bitonic_sort_eight_words64.sv @@
`timescale 1ns / 100ps

module tb_bitonic_sort_eight_words64;

    localparam int WORD_WIDTH = bitsort8_pkg::WORD_WIDTH;
    localparam int NUM_ELEMS = bitsort8_pkg::NUM_ELEMS;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [NUM_ELEMS-1:0][WORD_WIDTH-1:0] octet_t;

    localparam int RUN_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int LONG_HOLD = 90;
    localparam int TAIL_CYCLES = 24;

    // Compare-exchange pairs of the flip-form network, six layers of four, written as
    // two octal digits {lower position, upper position}.
    localparam logic [0:23][5:0] NET_PAIRS = {
        6'o01, 6'o23, 6'o45, 6'o67,
        6'o03, 6'o12, 6'o47, 6'o56,
        6'o01, 6'o23, 6'o45, 6'o67,
        6'o07, 6'o16, 6'o25, 6'o34,
        6'o02, 6'o13, 6'o46, 6'o57,
        6'o01, 6'o23, 6'o45, 6'o67
    };

    localparam word_t TOP_BIT = word_t'(1) << (WORD_WIDTH - 1);

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    word_t s_elem_0 = '0;
    word_t s_elem_1 = '0;
    word_t s_elem_2 = '0;
    word_t s_elem_3 = '0;
    word_t s_elem_4 = '0;
    word_t s_elem_5 = '0;
    word_t s_elem_6 = '0;
    word_t s_elem_7 = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    word_t m_sorted_0;
    word_t m_sorted_1;
    word_t m_sorted_2;
    word_t m_sorted_3;
    word_t m_sorted_4;
    word_t m_sorted_5;
    word_t m_sorted_6;
    word_t m_sorted_7;

    octet_t pending [$];
    octet_t sorted_due [$];
    octet_t offered = '0;
    int     send_gap = 0;
    int     items_sent = 0;
    int     ready_hold = 0;
    int     results_seen = 0;
    int     fail_count = 0;
    int     cycle_count = 0;

    bitonic_sort_eight_words64 u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_elem_0   (s_elem_0),
        .s_elem_1   (s_elem_1),
        .s_elem_2   (s_elem_2),
        .s_elem_3   (s_elem_3),
        .s_elem_4   (s_elem_4),
        .s_elem_5   (s_elem_5),
        .s_elem_6   (s_elem_6),
        .s_elem_7   (s_elem_7),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sorted_0 (m_sorted_0),
        .m_sorted_1 (m_sorted_1),
        .m_sorted_2 (m_sorted_2),
        .m_sorted_3 (m_sorted_3),
        .m_sorted_4 (m_sorted_4),
        .m_sorted_5 (m_sorted_5),
        .m_sorted_6 (m_sorted_6),
        .m_sorted_7 (m_sorted_7)
    );

    always #6 aclk = ~aclk;

    function automatic octet_t sort_octet(octet_t raw);
        octet_t w;
        word_t  lo_w;
        word_t  hi_w;
        int     a;
        int     b;
        w = raw;
        for (int p = 0; p < 24; p++) begin
            a = NET_PAIRS[p][5:3];
            b = NET_PAIRS[p][2:0];
            lo_w = w[a];
            hi_w = w[b];
            if (hi_w < lo_w) begin
                w[a] = hi_w;
                w[b] = lo_w;
            end
        end
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    function automatic word_t extreme_word();
        case ($urandom_range(0, 5))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return word_t'(1);
            end
            3: begin
                return ~word_t'(1);
            end
            4: begin
                return TOP_BIT;
            end
            default: begin
                return ~TOP_BIT;
            end
        endcase
    endfunction

    function automatic octet_t random_octet();
        octet_t w;
        octet_t flipped;
        word_t  pool [3];
        int     shape;
        shape = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++) begin
            pool[k] = word_t'({$urandom, $urandom});
        end
        for (int k = 0; k < NUM_ELEMS; k++) begin
            if (shape < 40) begin
                w[k] = word_t'({$urandom, $urandom});
            end else if (shape < 60) begin
                w[k] = pool[$urandom_range(0, 2)];
            end else if (shape < 72) begin
                w[k] = word_t'($urandom_range(0, 3));
            end else if (shape < 84) begin
                w[k] = extreme_word();
            end else if (shape < 92) begin
                w[k] = pool[0] ^ word_t'($urandom_range(0, 255));
            end else begin
                w[k] = pool[0] ^ (word_t'($urandom_range(0, 255)) << (WORD_WIDTH - 8));
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            w = sort_octet(w);
            if ($urandom_range(0, 1) == 1) begin
                for (int k = 0; k < NUM_ELEMS; k++) begin
                    flipped[k] = w[NUM_ELEMS - 1 - k];
                end
                w = flipped;
            end
        end
        return w;
    endfunction

    task automatic queue_item(input word_t e0, input word_t e1, input word_t e2,
                              input word_t e3, input word_t e4, input word_t e5,
                              input word_t e6, input word_t e7);
        pending.push_back({e7, e6, e5, e4, e3, e2, e1, e0});
    endtask

    always @(posedge aclk) begin : tx_side
        octet_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                sorted_due.push_back(sort_octet(offered));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending.size() > 0) begin
                    next_item = pending.pop_front();
                    offered <= next_item;
                    s_valid <= 1'b1;
                    s_elem_0 <= next_item[0];
                    s_elem_1 <= next_item[1];
                    s_elem_2 <= next_item[2];
                    s_elem_3 <= next_item[3];
                    s_elem_4 <= next_item[4];
                    s_elem_5 <= next_item[5];
                    s_elem_6 <= next_item[6];
                    s_elem_7 <= next_item[7];
                    send_gap <= (items_sent % 300 < 40) ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : rx_side
        octet_t got;
        octet_t want;
        int     hold_next;
        int     taken;
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold <= 0;
        end else begin
            hold_next = ready_hold;
            taken = results_seen;
            if (m_valid && m_ready) begin
                got = {m_sorted_7, m_sorted_6, m_sorted_5, m_sorted_4,
                       m_sorted_3, m_sorted_2, m_sorted_1, m_sorted_0};
                if (sorted_due.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, got %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = sorted_due.pop_front();
                    for (int k = 0; k < NUM_ELEMS; k++) begin
                        if (got[k] !== want[k]) begin
                            $display("%0t: sorted_%0d expected %h, got %h",
                                     $time, k, want[k], got[k]);
                            fail_count++;
                        end
                    end
                end
                taken = results_seen + 1;
                results_seen <= taken;
                // Hold the output off long enough for the pipeline to fill and
                // push back on the input.
                if (taken % 700 == 250) begin
                    hold_next = LONG_HOLD;
                end
            end
            if (hold_next > 0) begin
                m_ready <= 1'b0;
                ready_hold <= hold_next - 1;
            end else begin
                m_ready <= 1'b1;
                if (taken % 300 >= 150 && taken % 300 < 190) begin
                    ready_hold <= 0;
                end else begin
                    ready_hold <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("bitonic_sort_eight_words64 verification failed");
            $finish;
        end
    end

    initial begin
        queue_item('0, '0, '0, '0, '0, '0, '0, '0);
        queue_item('1, '1, '1, '1, '1, '1, '1, '1);
        queue_item(0, 1, 2, 3, 4, 5, 6, 7);
        queue_item(7, 6, 5, 4, 3, 2, 1, 0);
        queue_item('1, '0, '1, '0, '1, '0, '1, '0);
        queue_item('1, '0, '0, '0, '0, '0, '0, '0);
        queue_item('1, '1, '1, '1, '1, '1, '1, '0);
        queue_item(TOP_BIT, ~TOP_BIT, 1, '1, 0, TOP_BIT + 1, ~TOP_BIT - 1, 2);
        queue_item(5, 5, 3, 3, 9, 9, 1, 1);
        queue_item({(WORD_WIDTH / 2){2'b10}}, {(WORD_WIDTH / 2){2'b01}},
                   {(WORD_WIDTH / 2){2'b10}}, {(WORD_WIDTH / 2){2'b01}},
                   {(WORD_WIDTH / 2){2'b01}}, {(WORD_WIDTH / 2){2'b10}},
                   {(WORD_WIDTH / 2){2'b01}}, {(WORD_WIDTH / 2){2'b10}});
        queue_item(word_t'(1) << 63, word_t'(1) << 54, word_t'(1) << 45, word_t'(1) << 36,
                   word_t'(1) << 27, word_t'(1) << 18, word_t'(1) << 9, word_t'(1));
        queue_item(64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdee,
                   64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdf0,
                   64'h8123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef,
                   64'h0123_4567_89ab_cded, 64'h0123_4567_89ab_cdef);
        queue_item(3, 0, 7, 4, 1, 6, 5, 2);
        queue_item(4, 5, 6, 7, 0, 1, 2, 3);
        queue_item(~word_t'(1), '1, ~word_t'(2), '1, ~word_t'(1), ~word_t'(3), '1, '1);
        queue_item(64'hdead_beef_0000_0000, 64'h0000_0000_dead_beef,
                   64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff,
                   64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe,
                   64'hdead_beef_0000_0000, 64'h0000_0000_0000_0001);
        queue_item(2, 2, 2, 2, 2, 2, 2, 1);
        queue_item(1, 2, 2, 2, 2, 2, 2, 2);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pending.push_back(random_octet());
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() > 0 || s_valid || sorted_due.size() > 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && sorted_due.size() == 0) begin
            $display("bitonic_sort_eight_words64 verification clean");
        end else begin
            $display("bitonic_sort_eight_words64 verification failed");
        end
        $finish;
    end

endmodule
